// ===== sv/prs_pkg.sv =====
package prs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_WINDOW_DEPTH = 8;
    localparam int DEF_ADC_BITS     = 12;

    // Fixed field widths.
    localparam int MV_W      = 20;
    localparam int TIME_W    = 32;
    localparam int SCALE_W   = 5;
    localparam int REF_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_W    = 3;

    localparam logic [MV_W-1:0] MV_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERVOLT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERVOLT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SRC   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FB    = 3'd7;

    // Rail state codes on the result channel.
    localparam logic [CODE_W-1:0] CODE_OFF      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ENABLED  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SETTLING = 3'd2;
    localparam logic [CODE_W-1:0] CODE_STABLE   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_FAULT    = 3'd4;

    // Request commands.
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic mul_scale;
        logic mul_ref;
        logic remove;
        logic insert;
        logic median;
        logic step;
    } t_dp_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic sample_in;
        logic window_full;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== sv/power_rail_supervisor.sv =====
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_cmd .. i_good_active
// result    out        o_out_valid / i_out_ready  o_rail_state .. o_filtered_mv
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// A set request or a tick without a usable sample goes from acceptance straight to the step state.
// A tick with a fresh valid sample takes a longer path, with a removal when the window is full; the
// sequencer walks two multiplier stages, the sorted-window update and the median read.
// Reset is synchronous and active low; the sample window itself is not cleared.
// A new request is taken while the previous result waits; a stalled result holds the
// sequencer in its last step.
module power_rail_supervisor #(
    parameter int WINDOW_DEPTH = prs_pkg::DEF_WINDOW_DEPTH,
    parameter int ADC_BITS     = prs_pkg::DEF_ADC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [prs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic                          i_enable,
    input  logic [prs_pkg::TIME_W-1:0]    i_timer_value,
    input  logic                          i_adc_new,
    input  logic [ADC_BITS-1:0]           i_adc_sample,
    input  logic                          i_adc_invalid,
    input  logic                          i_source_stable,
    input  logic                          i_fault_active,
    input  logic                          i_good_active,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [prs_pkg::CODE_W-1:0]    o_rail_state,
    output logic                          o_state_changed,
    output logic                          o_enable_drive,
    output logic                          o_rail_good,
    output logic [prs_pkg::MV_W-1:0]      o_filtered_mv
);

    prs_pkg::t_dp_cmd    dp_cmd;
    prs_pkg::t_dp_status dp_status;

    prs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    prs_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADC_BITS     (ADC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_enable        (i_enable),
        .i_timer_value   (i_timer_value),
        .i_adc_new       (i_adc_new),
        .i_adc_sample    (i_adc_sample),
        .i_adc_invalid   (i_adc_invalid),
        .i_source_stable (i_source_stable),
        .i_fault_active  (i_fault_active),
        .i_good_active   (i_good_active),
        .i_out_ready     (i_out_ready),
        .i_dp_cmd        (dp_cmd),
        .o_status        (dp_status),
        .o_out_valid     (o_out_valid),
        .o_rail_state    (o_rail_state),
        .o_state_changed (o_state_changed),
        .o_enable_drive  (o_enable_drive),
        .o_rail_good     (o_rail_good),
        .o_filtered_mv   (o_filtered_mv)
    );

endmodule

// ===== sv/prs_ctrl.sv =====
module prs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  prs_pkg::t_dp_status i_status,
    output prs_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL1   = 7'b0000010,
        S_MUL2   = 7'b0000100,
        S_REMOVE = 7'b0001000,
        S_INSERT = 7'b0010000,
        S_MEDIAN = 7'b0100000,
        S_STEP   = 7'b1000000
    } t_ctrl_state;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.sample_in ? S_MUL1 : S_STEP;
                end
            end
            S_MUL1:   n_state = S_MUL2;
            S_MUL2: begin
                // A full window first drops the sample that is about to be overwritten.
                n_state = i_status.window_full ? S_REMOVE : S_INSERT;
            end
            S_REMOVE: n_state = S_INSERT;
            S_INSERT: n_state = S_MEDIAN;
            S_MEDIAN: n_state = S_STEP;
            S_STEP: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = accept;
        o_cmd.mul_scale = (r_state == S_MUL1);
        o_cmd.mul_ref   = (r_state == S_MUL2);
        o_cmd.remove    = (r_state == S_REMOVE);
        o_cmd.insert    = (r_state == S_INSERT);
        o_cmd.median    = (r_state == S_MEDIAN);
        o_cmd.step      = (r_state == S_STEP) && !i_status.out_busy;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

// ===== sv/prs_datapath.sv =====
module prs_datapath #(
    parameter int WINDOW_DEPTH = prs_pkg::DEF_WINDOW_DEPTH,
    parameter int ADC_BITS     = prs_pkg::DEF_ADC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_cmd,
    input  logic                               i_enable,
    input  logic [prs_pkg::TIME_W-1:0]         i_timer_value,
    input  logic                               i_adc_new,
    input  logic [ADC_BITS-1:0]                i_adc_sample,
    input  logic                               i_adc_invalid,
    input  logic                               i_source_stable,
    input  logic                               i_fault_active,
    input  logic                               i_good_active,
    input  logic                               i_out_ready,
    input  prs_pkg::t_dp_cmd                   i_dp_cmd,
    output prs_pkg::t_dp_status                o_status,
    output logic                               o_out_valid,
    output logic [prs_pkg::CODE_W-1:0]         o_rail_state,
    output logic                               o_state_changed,
    output logic                               o_enable_drive,
    output logic                               o_rail_good,
    output logic [prs_pkg::MV_W-1:0]           o_filtered_mv
);

    localparam int MV_W   = prs_pkg::MV_W;
    localparam int TIME_W = prs_pkg::TIME_W;
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int P1_W   = ADC_BITS + prs_pkg::SCALE_W;
    localparam int P2_W   = P1_W + prs_pkg::REF_W;
    localparam int HI_W   = P2_W - ADC_BITS;

    localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    typedef enum logic [4:0] {
        RAIL_OFF      = 5'b00001,
        RAIL_ENABLED  = 5'b00010,
        RAIL_SETTLING = 5'b00100,
        RAIL_STABLE   = 5'b01000,
        RAIL_FAULT    = 5'b10000
    } t_rail;

    function automatic logic [prs_pkg::CODE_W-1:0] rail_code(input t_rail m);
        logic [prs_pkg::CODE_W-1:0] c;
        unique case (m)
            RAIL_OFF:      c = prs_pkg::CODE_OFF;
            RAIL_ENABLED:  c = prs_pkg::CODE_ENABLED;
            RAIL_SETTLING: c = prs_pkg::CODE_SETTLING;
            RAIL_STABLE:   c = prs_pkg::CODE_STABLE;
            RAIL_FAULT:    c = prs_pkg::CODE_FAULT;
            default:       c = prs_pkg::CODE_OFF;
        endcase
        return c;
    endfunction

    // The pins only count once the rail has reached the stable or fault state.
    function automatic logic rail_good_f(input t_rail m, input logic v_ok,
                                         input logic fb_en, input logic pins_ok);
        logic fb_ok;
        fb_ok = !(fb_en && ((m == RAIL_STABLE) || (m == RAIL_FAULT))) || pins_ok;
        return (m != RAIL_OFF) && v_ok && fb_ok;
    endfunction

    // Configuration registers.
    logic [MV_W-1:0]             r_undervolt;
    logic [MV_W-1:0]             r_overvolt;
    logic [TIME_W-1:0]           r_rise;
    logic [TIME_W-1:0]           r_settle;
    logic [prs_pkg::SCALE_W-1:0] r_scale;
    logic [prs_pkg::REF_W-1:0]   r_ref;
    logic                        r_use_src;
    logic                        r_use_fb;

    // Captured request.
    logic                r_is_tick;
    logic                r_enable;
    logic [TIME_W-1:0]   r_timer_value;
    logic [ADC_BITS-1:0] r_sample;
    logic                r_source_stable;
    logic                r_fault;
    logic                r_good;

    // Conversion and window.
    logic [P1_W-1:0]   r_prod1;
    logic [P2_W-1:0]   prod2;
    logic [HI_W-1:0]   prod_hi;
    logic [MV_W-1:0]   r_mv;
    logic [MV_W-1:0]   r_old;
    logic [MV_W-1:0]   r_window [WINDOW_DEPTH];
    logic [MV_W-1:0]   r_sorted [WINDOW_DEPTH];
    logic [MV_W-1:0]   removed  [WINDOW_DEPTH];
    logic [MV_W-1:0]   inserted [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] pref;
    logic [WINDOW_DEPTH-1:0] gt;
    logic              hit_run;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_slot;
    logic [MV_W-1:0]   r_voltage;

    // Rail state.
    t_rail             r_rail;
    t_rail             n_rail;
    logic [TIME_W-1:0] r_mark;
    logic [TIME_W-1:0] n_mark;
    logic [TIME_W-1:0] since_mark;
    logic              v_ok;
    logic              pins_ok;
    logic              good_cur;

    // Result register.
    logic                        r_out_valid;
    logic [prs_pkg::CODE_W-1:0]  r_out_state;
    logic                        r_out_changed;
    logic                        r_out_drive;
    logic                        r_out_good;
    logic [MV_W-1:0]             r_out_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undervolt <= '0;
            r_overvolt  <= prs_pkg::MV_MAX;
            r_rise      <= TIME_W'(1000);
            r_settle    <= TIME_W'(100);
            r_scale     <= prs_pkg::SCALE_W'(1);
            r_ref       <= prs_pkg::REF_W'(3300);
            r_use_src   <= 1'b0;
            r_use_fb    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                prs_pkg::CFG_UNDERVOLT: r_undervolt <= i_cfg_data[MV_W-1:0];
                prs_pkg::CFG_OVERVOLT:  r_overvolt  <= i_cfg_data[MV_W-1:0];
                prs_pkg::CFG_RISE:      r_rise      <= i_cfg_data[TIME_W-1:0];
                prs_pkg::CFG_SETTLE:    r_settle    <= i_cfg_data[TIME_W-1:0];
                prs_pkg::CFG_SCALE:     r_scale     <= i_cfg_data[prs_pkg::SCALE_W-1:0];
                prs_pkg::CFG_REF:       r_ref       <= i_cfg_data[prs_pkg::REF_W-1:0];
                prs_pkg::CFG_USE_SRC:   r_use_src   <= i_cfg_data[0];
                prs_pkg::CFG_USE_FB:    r_use_fb    <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_is_tick       <= (i_cmd == prs_pkg::CMD_TICK);
            r_enable        <= i_enable;
            r_timer_value   <= i_timer_value;
            r_sample        <= i_adc_sample;
            r_source_stable <= i_source_stable;
            r_fault         <= i_fault_active;
            r_good          <= i_good_active;
        end
    end

    // Two multiplier stages: sample times divider gain, then times the reference.
    assign prod2   = P2_W'(r_prod1) * P2_W'(r_ref);
    assign prod_hi = prod2[P2_W-1:ADC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.mul_scale) begin
            r_prod1 <= P1_W'(r_sample) * P1_W'(r_scale);
            r_old   <= r_window[r_slot];
        end
        if (i_dp_cmd.mul_ref) begin
            r_mv <= (prod_hi > HI_W'(prs_pkg::MV_MAX)) ? prs_pkg::MV_MAX : prod_hi[MV_W-1:0];
        end
        if (i_dp_cmd.insert) begin
            r_window[r_slot] <= r_mv;
        end
    end

    // The sorted copy drops one occurrence of the outgoing sample, then takes the new one.
    always_comb begin
        hit_run = 1'b0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            hit_run     = hit_run | (r_sorted[k] == r_old);
            pref[k]     = hit_run;
            removed[k]  = r_sorted[k];
            gt[k]       = (CNT_W'(k) >= r_count) || (r_sorted[k] > r_mv);
        end
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
            if (pref[k]) begin
                removed[k] = r_sorted[k + 1];
            end
        end
        inserted[0] = gt[0] ? r_mv : r_sorted[0];
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
            if (!gt[k]) begin
                inserted[k] = r_sorted[k];
            end else if (!gt[k - 1]) begin
                inserted[k] = r_mv;
            end else begin
                inserted[k] = r_sorted[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.remove) begin
            r_sorted <= removed;
        end else if (i_dp_cmd.insert) begin
            r_sorted <= inserted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_slot    <= '0;
            r_voltage <= '0;
        end else begin
            if (i_dp_cmd.remove) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_dp_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
                r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
            end
            if (i_dp_cmd.median) begin
                r_voltage <= r_sorted[SLOT_W'(r_count >> 1)];
            end
        end
    end

    assign since_mark = r_timer_value - r_mark;
    assign v_ok       = (r_voltage >= r_undervolt) && (r_voltage <= r_overvolt);
    assign pins_ok    = !r_fault && r_good;
    assign good_cur   = rail_good_f(r_rail, v_ok, r_use_fb, pins_ok);

    always_comb begin
        n_rail = r_rail;
        n_mark = r_mark;
        if (!r_is_tick) begin
            if (r_enable) begin
                if (r_rail == RAIL_OFF) begin
                    n_mark = r_timer_value;
                    n_rail = RAIL_ENABLED;
                end
            end else begin
                n_rail = RAIL_OFF;
            end
        end else begin
            unique case (r_rail)
                RAIL_ENABLED: begin
                    if (!r_use_src || r_source_stable) begin
                        if (since_mark >= r_rise) begin
                            n_rail = RAIL_FAULT;
                        end else if (good_cur) begin
                            n_mark = r_timer_value;
                            n_rail = RAIL_SETTLING;
                        end
                    end
                end
                RAIL_SETTLING: begin
                    if (since_mark >= r_settle) begin
                        n_rail = good_cur ? RAIL_STABLE : RAIL_FAULT;
                    end
                end
                RAIL_STABLE: begin
                    if (!good_cur) begin
                        n_rail = RAIL_FAULT;
                    end
                end
                RAIL_FAULT: begin
                    if (good_cur) begin
                        n_mark = r_timer_value;
                        n_rail = RAIL_SETTLING;
                    end
                end
                default: n_rail = r_rail;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail      <= RAIL_OFF;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dp_cmd.step) begin
                r_rail      <= n_rail;
                r_mark      <= n_mark;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.step) begin
            r_out_state   <= rail_code(n_rail);
            r_out_changed <= (n_rail != r_rail);
            r_out_drive   <= (n_rail != RAIL_OFF);
            r_out_good    <= rail_good_f(n_rail, v_ok, r_use_fb, pins_ok);
            r_out_mv      <= r_voltage;
        end
    end

    assign o_status.sample_in   = (i_cmd == prs_pkg::CMD_TICK) && i_adc_new && !i_adc_invalid;
    assign o_status.window_full = (r_count == DEPTH_C);
    assign o_status.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_rail_state    = r_out_state;
    assign o_state_changed = r_out_changed;
    assign o_enable_drive  = r_out_drive;
    assign o_rail_good     = r_out_good;
    assign o_filtered_mv   = r_out_mv;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("window count beyond depth");

    a_remove_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.remove |-> (r_count == DEPTH_C))
        else $error("sample removed from a window that is not full");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.insert |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the window");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.step |=> o_out_valid)
        else $error("step did not present a result");

endmodule
